[rtl/ffa_pkg.sv]
package ffa_pkg;

  localparam logic [31:0] QNAN_BITS  = 32'h7FC00000;
  localparam logic [31:0] PINF_BITS  = 32'h7F800000;
  localparam logic [31:0] NINF_BITS  = 32'h7F800000 | 32'h80000000;
  localparam logic [22:0] FRAC_MASK  = 23'h7FFFFF;
  localparam logic [23:0] HIDDEN_BIT = 24'h800000;
  localparam logic [7:0]  EXP_MASK   = 8'hFF;

  // special-case code carried down the pipe
  localparam logic [1:0] SPC_NONE = 2'd0;
  localparam logic [1:0] SPC_QNAN = 2'd1;
  localparam logic [1:0] SPC_PINF = 2'd2;
  localparam logic [1:0] SPC_NINF = 2'd3;

  // stage 1 -> stage 2: aligned operands
  typedef struct packed {
    logic [1:0]        spc;
    logic              any;
    logic              rsign;
    logic [7:0]        top;
    logic [3:0]        neg;
    logic [3:0][26:0]  al;
    logic [1:0]        merged; // 0 none, 1 plus, 2 minus
  } ffa_align_t;

  // stage 2 -> stage 3: signed sum
  typedef struct packed {
    logic [1:0]  spc;
    logic        any;
    logic        rsign;
    logic [7:0]  top;
    logic [30:0] acc;
  } ffa_sum_t;

endpackage

[rtl/ffa_align.sv]
module ffa_align (
  input  logic [31:0]        operand_a,
  input  logic [31:0]        operand_b,
  input  logic [31:0]        operand_c,
  input  logic [31:0]        operand_d,
  output ffa_pkg::ffa_align_t align
);

  logic [3:0][31:0] w;
  logic [3:0][7:0]  ex;
  logic [3:0]       sg;
  logic [3:0]       nz;
  logic [3:0][23:0] mn;
  logic             nan, pinf, ninf;
  logic [7:0]       top;
  logic [1:0]       ref_i;
  logic             any;
  logic [3:0]       lost;
  logic             pos, neg;
  logic [7:0]       sh;
  logic [26:0]      m3;

  function automatic logic [23:0] HIDDEN_BIT_F(input logic [22:0] f);
    HIDDEN_BIT_F = ffa_pkg::HIDDEN_BIT | {1'b0, f};
  endfunction

  assign w = {operand_d, operand_c, operand_b, operand_a};

  // classify operands and pick the reference
  always_comb begin
    nan = 1'b0; pinf = 1'b0; ninf = 1'b0;
    top = 8'd0; ref_i = 2'd0; any = 1'b0;
    for (int i = 0; i < 4; i++) begin
      ex[i] = w[i][30:23];
      sg[i] = w[i][31];
      nz[i] = (ex[i] != 8'd0);
      mn[i] = nz[i] ? (HIDDEN_BIT_F(w[i][22:0])) : 24'd0;
      if (ex[i] == ffa_pkg::EXP_MASK) begin
        if (w[i][22:0] != 23'd0) nan = 1'b1;
        else if (sg[i]) ninf = 1'b1;
        else pinf = 1'b1;
      end
      if (nz[i] && (!any || ex[i] > top)) begin
        top = ex[i]; ref_i = 2'(i); any = 1'b1;
      end
    end
  end

  // align to the largest exponent, collect sticky per side
  always_comb begin
    align = '0;
    pos = 1'b0; neg = 1'b0;
    lost = '0;
    for (int i = 0; i < 4; i++) begin
      sh = top - ex[i];
      m3 = {mn[i], 3'b000};
      if (!nz[i]) begin
        align.al[i] = 27'd0;
      end else if (sh >= 8'd27) begin
        align.al[i] = 27'd0;
        lost[i] = 1'b1;
      end else begin
        align.al[i] = m3 >> sh[4:0];
        lost[i] = (m3 & ~(27'h7FFFFFF << sh[4:0])) != 27'd0;
      end
      align.neg[i] = nz[i] && (sg[i] != sg[ref_i]);
      if (lost[i] && 2'(i) != ref_i) begin
        if (sg[i] == sg[ref_i]) pos = 1'b1;
        else neg = 1'b1;
      end
    end
    align.merged = (pos && !neg) ? 2'd1 : ((neg && !pos) ? 2'd2 : 2'd0);
    if (nan || (pinf && ninf)) align.spc = ffa_pkg::SPC_QNAN;
    else if (pinf) align.spc = ffa_pkg::SPC_PINF;
    else if (ninf) align.spc = ffa_pkg::SPC_NINF;
    else align.spc = ffa_pkg::SPC_NONE;
    align.any = any;
    align.rsign = sg[ref_i];
    align.top = top;
  end

endmodule

[rtl/ffa_norm.sv]
module ffa_norm (
  input  ffa_pkg::ffa_sum_t s,
  output logic [31:0]       sum_bits
);

  logic        neg;
  logic        rsign;
  logic [29:0] mag;
  logic [29:0] m;
  logic [4:0]  msb;
  logic [4:0]  lshift;
  logic [9:0]  rexp;
  logic [3:0]  low;
  logic [24:0] sig;

  // take magnitude, normalize to bit 27, round to nearest even
  always_comb begin
    neg = s.acc[30];
    rsign = s.rsign ^ neg;
    mag = neg ? 30'(-s.acc) : s.acc[29:0];
    msb = 5'd0;
    for (int b = 0; b < 30; b++) if (mag[b]) msb = 5'(b);
    rexp = {2'b00, s.top};
    m = mag;
    lshift = 5'd0;
    if (msb == 5'd29) begin
      m = {2'b00, mag[29:2]} | {29'd0, |mag[1:0]};
      rexp = rexp + 10'd2;
    end else if (msb == 5'd28) begin
      m = {1'b0, mag[29:1]} | {29'd0, mag[0]};
      rexp = rexp + 10'd1;
    end else if (msb < 5'd27) begin
      lshift = 5'd27 - msb;
      m = mag << lshift;
      rexp = rexp - {5'd0, lshift};
      if (lshift >= 5'd4) m[lshift] = 1'b0;
    end
    low = m[3:0];
    sig = {1'b0, m[27:4]};
    if (low > 4'd8 || (low == 4'd8 && sig[0])) sig = sig + 25'd1;
    if (sig[24]) begin
      sig = sig >> 1;
      rexp = rexp + 10'd1;
    end
    if (s.spc == ffa_pkg::SPC_QNAN) sum_bits = ffa_pkg::QNAN_BITS;
    else if (s.spc == ffa_pkg::SPC_PINF) sum_bits = ffa_pkg::PINF_BITS;
    else if (s.spc == ffa_pkg::SPC_NINF) sum_bits = ffa_pkg::NINF_BITS;
    else if (!s.any || s.acc == 31'd0) sum_bits = 32'd0;
    else if (rexp[9] || rexp == 10'd0) sum_bits = 32'd0;
    else if (rexp >= 10'd255) sum_bits = {rsign, 31'h7F800000};
    else sum_bits = {rsign, rexp[7:0], sig[22:0] & ffa_pkg::FRAC_MASK};
  end

endmodule

[rtl/fused_four_operand_fp32_adder.sv]
// Pipeline stages from input transaction to result: align, sum, normalize, output.
// Throughput: one transaction per cycle; the pipeline stalls as a whole only
// when the output register is full and out_ready is low.
// Reset: rst_n synchronous active low clears all stage valid bits; payload
// registers are not reset.
module fused_four_operand_fp32_adder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  input  logic [31:0] in_operand_c,
  input  logic [31:0] in_operand_d,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sum_bits
);

  logic                v1_r, v2_r, v3_r, v4_r;
  logic [3:0][31:0]    op_r;
  ffa_pkg::ffa_align_t al_nxt, al_r;
  ffa_pkg::ffa_sum_t   sm_nxt, sm_r;
  logic [31:0]         res_nxt, res_r;
  logic                adv;

  // whole pipe moves when the output slot is free or being taken
  assign adv = !v4_r || out_ready;
  assign in_ready = adv;
  assign out_valid = v4_r;
  assign out_sum_bits = res_r;

  ffa_align u_align (
    .operand_a(op_r[0]), .operand_b(op_r[1]),
    .operand_c(op_r[2]), .operand_d(op_r[3]),
    .align(al_nxt)
  );

  // signed sum about the reference sign
  always_comb begin
    logic signed [30:0] acc;
    acc = '0;
    for (int i = 0; i < 4; i++) begin
      if (al_r.neg[i]) acc = acc - $signed({3'b000, al_r.al[i], 1'b0});
      else acc = acc + $signed({3'b000, al_r.al[i], 1'b0});
    end
    if (al_r.merged == 2'd1) acc = acc + 31'sd1;
    else if (al_r.merged == 2'd2) acc = acc - 31'sd1;
    sm_nxt.spc = al_r.spc;
    sm_nxt.any = al_r.any;
    sm_nxt.rsign = al_r.rsign;
    sm_nxt.top = al_r.top;
    sm_nxt.acc = acc;
  end

  ffa_norm u_norm (.s(sm_r), .sum_bits(res_nxt));

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      op_r  <= {in_operand_d, in_operand_c, in_operand_b, in_operand_a};
      al_r  <= al_nxt;
      sm_r  <= sm_nxt;
      res_r <= res_nxt;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sum_bits))
    else $error("result dropped under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("stall without pending result");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v1_r)
    else $error("accepted transaction lost");

endmodule
